FILE: src/ebrc_pkg.sv
// ----------------------------------------------------------------------------
// ebrc_pkg
// Types, opcodes and constants shared by the 8-bit RISC step core.
// ----------------------------------------------------------------------------
`default_nettype none

package ebrc_pkg;

   // Instruction formats, taken from the top two bits of the word.
   typedef enum logic [1:0] {
      FMT_RALU = 2'd0,
      FMT_IALU = 2'd1,
      FMT_MEM  = 2'd2,
      FMT_JMP  = 2'd3
   } ebrc_fmt_type;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_ADC  = 4'd1,
      OP_SUB  = 4'd2,
      OP_SBC  = 4'd3,
      OP_CMP  = 4'd4,
      OP_CMC  = 4'd5,
      OP_AND  = 4'd6,
      OP_OR   = 4'd7,
      OP_XOR  = 4'd8,
      OP_SHL  = 4'd9,
      OP_SHR  = 4'd10,
      OP_RSVD = 4'd11,
      OP_MOV  = 4'd12,
      OP_INS  = 4'd13,
      OP_TSB  = 4'd14,
      OP_BST  = 4'd15
   } ebrc_op_type;

   // Address modes of the load/store format.
   typedef enum logic [2:0] {
      MEM_SP = 3'd0,
      MEM_FP = 3'd1,
      MEM_RA = 3'd2,
      MEM_GB = 3'd3,
      MEM_GE = 3'd4,
      MEM_GF = 3'd5,
      MEM_GG = 3'd6,
      MEM_GH = 3'd7
   } ebrc_mem_mode_type;

   // Target modes of the jump/call format.
   typedef enum logic [2:0] {
      JMP_LOW  = 3'd0,
      JMP_HIGH = 3'd1,
      JMP_REL  = 3'd2,
      JMP_RA   = 3'd3,
      JMP_GE   = 3'd4,
      JMP_GF   = 3'd5,
      JMP_GG   = 3'd6,
      JMP_GH   = 3'd7
   } ebrc_jmp_mode_type;

   typedef enum logic [2:0] {
      COND_C      = 3'd0,
      COND_V      = 3'd1,
      COND_N      = 3'd2,
      COND_Z      = 3'd3,
      COND_GT     = 3'd4,
      COND_GE     = 3'd5,
      COND_HI     = 3'd6,
      COND_ALWAYS = 3'd7
   } ebrc_cond_type;

   localparam int NUM_REGS = 16;
   localparam logic [3:0] SR_INDEX = 4'd2;
   localparam logic [3:0] SP_INDEX = 4'd3;
   localparam logic [3:0] FP_INDEX = 4'd4;
   localparam logic [3:0] GB_INDEX = 4'd5;
   localparam logic [3:0] RA_INDEX = 4'd0;

   localparam int FLAG_C_BIT = 3;
   localparam int FLAG_V_BIT = 2;
   localparam int FLAG_N_BIT = 1;
   localparam int FLAG_Z_BIT = 0;

   // Per-opcode masks: result written to register x, status register written.
   localparam logic [15:0] WRITE_SET = 16'b1011011111001111;
   localparam logic [15:0] FLAGS_SET = 16'b1100011111111111;

   localparam logic [15:0] STACK_BASE = 16'h0100;
   localparam logic [15:0] PAGE_BASE  = 16'h0200;
   localparam logic [15:0] LOW_BUILD  = 16'h0040;
   localparam logic [15:0] HIGH_BUILD = 16'h00C0;

   typedef logic [NUM_REGS-1:0][7:0] ebrc_regs_type;

   // Architectural state as seen by the execute logic.
   typedef struct packed {
      ebrc_regs_type regs;
      logic [15:0]   pc;
      logic          pending;
      logic [3:0]    target;
   } ebrc_state_type;

   // State update produced by one executed transaction. Priority inside the
   // register file: register x write, then return address, then status.
   typedef struct packed {
      logic [15:0] pc;
      logic        sr_we;
      logic [7:0]  sr;
      logic        ra_we;
      logic [15:0] ra;
      logic        x_we;
      logic [3:0]  x_idx;
      logic [7:0]  x_data;
      logic        ld_set;
      logic [3:0]  ld_tgt;
   } ebrc_upd_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        mem_load;
      logic        mem_store;
      logic [15:0] mem_addr;
      logic [7:0]  store_data;
      logic        illegal;
      logic [3:0]  flags;
   } ebrc_rsp_type;

endpackage

`default_nettype wire

FILE: src/eight_bit_risc_core_step.sv
// The request is held in an input register and executed from there; its
// response is registered on the rsp_ channel.
// Throughput: one instruction or load delivery per cycle while the rsp_
// channel accepts; the register file and program counter update in the
// execute cycle, so the next transaction sees them without a bubble.
// Reset clears all registers, status, pc and the pending load.
// ----------------------------------------------------------------------------
// eight_bit_risc_core_step
// Top level: request register, combinational execute and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_bit_risc_core_step
   import ebrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // instruction[15:0], load_data[23:16]
   input  wire logic        req_tuser,  // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // next_pc[15:0], mem_load[16], mem_store[17], mem_addr[33:18],
   // store_data[41:34], illegal[42], flags[46:43], zero[47]
   output logic [47:0]      rsp_tdata
);

   logic           in_valid_ff;
   logic           in_cmd_ff;
   logic [15:0]    in_ins_ff;
   logic [7:0]     in_ld_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [47:0]    rsp_data_ff;
   logic           exec_fire;
   logic           req_take;
   ebrc_state_type state;
   ebrc_upd_type   upd;
   ebrc_rsp_type   res;

   assign exec_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || exec_fire;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff <= req_tuser;
         in_ins_ff <= req_tdata[15:0];
         in_ld_ff  <= req_tdata[23:16];
      end
   end

   ebrc_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .en    (exec_fire),
      .upd   (upd),
      .state (state)
   );

   ebrc_exec u_exec (
      .cmd         (in_cmd_ff),
      .instruction (in_ins_ff),
      .load_data   (in_ld_ff),
      .state       (state),
      .upd         (upd),
      .rsp         (res)
   );

   always_comb begin
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_data_ff <= {1'b0, res.flags, res.illegal, res.store_data, res.mem_addr,
                         res.mem_store, res.mem_load, res.next_pc};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_fire_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff)
      else $error("executed transaction produced no response");

   a_load_marks_pending : assert property (@(posedge clock) disable iff (reset)
      (exec_fire && res.mem_load) |=> (state.pending && state.target == $past(in_ins_ff[7:4])))
      else $error("load did not record its pending target");

   a_mem_exclusive : assert property (@(posedge clock) disable iff (reset)
      exec_fire |-> !(res.mem_load && res.mem_store))
      else $error("load and store requested together");

   a_delivery_keeps_pc : assert property (@(posedge clock) disable iff (reset)
      (exec_fire && in_cmd_ff) |=> (state.pc == $past(state.pc) && !state.pending))
      else $error("load delivery changed pc or left a load pending");

   a_illegal_no_access : assert property (@(posedge clock) disable iff (reset)
      (exec_fire && res.illegal) |-> (!res.mem_load && !res.mem_store && !upd.x_we
                                      && !upd.sr_we))
      else $error("illegal opcode changed state or accessed memory");

endmodule

`default_nettype wire

FILE: src/ebrc_regfile.sv
// ----------------------------------------------------------------------------
// ebrc_regfile
// Byte register file, program counter and pending-load tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module ebrc_regfile
   import ebrc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire ebrc_upd_type   upd,
   output ebrc_state_type      state
);

   ebrc_regs_type regs_ff, regs_in;
   logic [15:0]   pc_ff;
   logic          pending_ff;
   logic [3:0]    target_ff;

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (upd.x_we && (upd.x_idx == 4'(i))) begin
            regs_in[i] = upd.x_data;
         end else if (upd.ra_we && (4'(i) == RA_INDEX)) begin
            regs_in[i] = upd.ra[7:0];
         end else if (upd.ra_we && (4'(i) == RA_INDEX + 4'd1)) begin
            regs_in[i] = upd.ra[15:8];
         end else if (upd.sr_we && (4'(i) == SR_INDEX)) begin
            regs_in[i] = upd.sr;
         end else begin
            regs_in[i] = regs_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff    <= '0;
         pc_ff      <= '0;
         pending_ff <= 1'b0;
         target_ff  <= '0;
      end else if (en) begin
         regs_ff    <= regs_in;
         pc_ff      <= upd.pc;
         pending_ff <= upd.ld_set;
         target_ff  <= upd.ld_tgt;
      end
   end

   assign state.regs    = regs_ff;
   assign state.pc      = pc_ff;
   assign state.pending = pending_ff;
   assign state.target  = target_ff;

endmodule

`default_nettype wire

FILE: src/ebrc_alu.sv
// ----------------------------------------------------------------------------
// ebrc_alu
// Byte ALU: arithmetic, logic, shifts and bit operations with flag update.
// ----------------------------------------------------------------------------
`default_nettype none

module ebrc_alu
   import ebrc_pkg::*;
(
   input  wire ebrc_op_type op,
   input  wire logic [7:0]  a,
   input  wire logic [7:0]  b,
   input  wire logic [7:0]  sr_in,
   output logic [7:0]       res,
   output logic [7:0]       sr_out
);

   always_comb begin
      logic [7:0] bb;
      logic       cin;
      logic [8:0] sum;
      logic [7:0] sr;

      // Subtract forms add the inverted operand.
      bb = ((op == OP_SUB) || (op == OP_SBC) || (op == OP_CMP) || (op == OP_CMC)) ? ~b : b;
      if (op == OP_ADD) begin
         cin = 1'b0;
      end else if ((op == OP_SUB) || (op == OP_CMP)) begin
         cin = 1'b1;
      end else begin
         cin = sr_in[FLAG_C_BIT];
      end
      sum = {1'b0, a} + {1'b0, bb} + {8'd0, cin};
      sr  = sr_in;
      res = a;

      unique case (op)
         OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CMP, OP_CMC: begin
            res            = sum[7:0];
            sr[FLAG_C_BIT] = sum[8];
            sr[FLAG_V_BIT] = (a[7] == bb[7]) && (a[7] != sum[7]);
         end
         OP_AND:  res = a & bb;
         OP_OR:   res = a | bb;
         OP_XOR:  res = a ^ bb;
         OP_SHL:  res = a << bb[2:0];
         OP_SHR:  res = a >> bb[2:0];
         OP_MOV:  res = bb;
         OP_INS:  res = {bb[1:0], a[5:0]};
         OP_BST:  res[bb[2:0]] = bb[3];
         OP_TSB, OP_RSVD: res = '0;
         default: res = '0;
      endcase

      // The carry-chained forms only ever clear Z.
      if (op == OP_TSB) begin
         sr[FLAG_Z_BIT] = a[bb[2:0]];
      end else if ((op == OP_ADC) || (op == OP_SBC) || (op == OP_CMC)) begin
         if (res != 8'd0) begin
            sr[FLAG_Z_BIT] = 1'b0;
         end
      end else begin
         sr[FLAG_Z_BIT] = (res == 8'd0);
      end

      if (op == OP_TSB) begin
         sr[FLAG_N_BIT] = (bb[5:3] == 3'd0) && bb[0];
      end else begin
         sr[FLAG_N_BIT] = res[7];
      end

      sr_out = sr;
   end

endmodule

`default_nettype wire

FILE: src/ebrc_exec.sv
// ----------------------------------------------------------------------------
// ebrc_exec
// Instruction decode, address and target generation, state update and
// result assembly for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ebrc_exec
   import ebrc_pkg::*;
(
   input  wire logic           cmd,
   input  wire logic [15:0]    instruction,
   input  wire logic [7:0]     load_data,
   input  wire ebrc_state_type state,
   output ebrc_upd_type        upd,
   output ebrc_rsp_type        rsp
);

   ebrc_fmt_type fmt;
   ebrc_op_type  op;
   logic [3:0]   x;
   logic [7:0]   imm;
   logic [7:0]   sr_old;
   logic [7:0]   alu_b;
   logic [7:0]   alu_res;
   logic [7:0]   alu_sr;
   logic [15:0]  pc_adv;

   assign fmt    = ebrc_fmt_type'(instruction[15:14]);
   assign op     = ebrc_op_type'(instruction[13:10]);
   assign x      = instruction[7:4];
   // Six-bit immediate, sign-extended to a byte.
   assign imm    = {{2{instruction[9]}}, instruction[9:8], instruction[3:0]};
   assign sr_old = state.regs[SR_INDEX];
   assign pc_adv = state.pc + 16'd2;
   assign alu_b  = (fmt == FMT_IALU) ? imm : state.regs[instruction[3:0]];

   ebrc_alu u_alu (
      .op     (op),
      .a      (state.regs[x]),
      .b      (alu_b),
      .sr_in  (sr_old),
      .res    (alu_res),
      .sr_out (alu_sr)
   );

   always_comb begin
      logic [15:0] base;
      logic [7:0]  off;
      logic [15:0] sum16;
      logic        fc, fv, fn, fz, ge, jump;
      logic [3:0]  pair_lo;
      logic [7:0]  sr_final;

      upd        = '0;
      upd.pc     = state.pc;
      upd.ld_tgt = state.target;
      rsp        = '0;
      base       = '0;
      off        = '0;
      sum16      = '0;
      jump       = 1'b0;
      fc         = sr_old[FLAG_C_BIT];
      fv         = sr_old[FLAG_V_BIT];
      fn         = sr_old[FLAG_N_BIT];
      fz         = sr_old[FLAG_Z_BIT];
      ge         = fv ? fc : !fn;
      pair_lo    = {1'b1, instruction[11:10], 1'b0};

      if (cmd) begin
         // Load delivery: only lands when a load is outstanding.
         if (state.pending) begin
            upd.x_we   = 1'b1;
            upd.x_idx  = state.target;
            upd.x_data = load_data;
         end
         rsp.next_pc = state.pc;
      end else begin
         upd.pc = pc_adv;
         unique case (fmt)
            FMT_RALU, FMT_IALU: begin
               if (op == OP_RSVD) begin
                  rsp.illegal = 1'b1;
               end else begin
                  upd.sr_we  = FLAGS_SET[op];
                  upd.sr     = alu_sr;
                  upd.x_we   = WRITE_SET[op];
                  upd.x_idx  = x;
                  upd.x_data = alu_res;
               end
            end
            FMT_MEM: begin
               unique case (ebrc_mem_mode_type'(instruction[12:10]))
                  MEM_SP:  base = STACK_BASE | {8'd0, state.regs[SP_INDEX]};
                  MEM_FP:  base = STACK_BASE | {8'd0, state.regs[FP_INDEX]};
                  MEM_RA:  base = {state.regs[RA_INDEX + 4'd1], state.regs[RA_INDEX]};
                  MEM_GB:  base = PAGE_BASE | {8'd0, state.regs[GB_INDEX]};
                  MEM_GE, MEM_GF, MEM_GG, MEM_GH:
                     base = {state.regs[pair_lo + 4'd1], state.regs[pair_lo]};
                  default: base = '0;
               endcase
               off          = imm;
               sum16        = base + {{8{off[7]}}, off};
               rsp.mem_addr = sum16;
               if (instruction[13]) begin
                  rsp.mem_store  = 1'b1;
                  rsp.store_data = state.regs[x];
               end else begin
                  rsp.mem_load = 1'b1;
                  upd.ld_set   = 1'b1;
                  upd.ld_tgt   = x;
               end
            end
            FMT_JMP: begin
               unique case (ebrc_jmp_mode_type'(instruction[12:10]))
                  JMP_LOW:  base = LOW_BUILD;
                  JMP_HIGH: base = HIGH_BUILD;
                  JMP_REL:  base = pc_adv;
                  JMP_RA:   base = {state.regs[RA_INDEX + 4'd1], state.regs[RA_INDEX]};
                  JMP_GE, JMP_GF, JMP_GG, JMP_GH:
                     base = {state.regs[pair_lo + 4'd1], state.regs[pair_lo]};
                  default:  base = '0;
               endcase
               unique case (ebrc_cond_type'(instruction[6:4]))
                  COND_C:      jump = fc;
                  COND_V:      jump = fv;
                  COND_N:      jump = fn;
                  COND_Z:      jump = fz;
                  COND_GT:     jump = ge && !fz;
                  COND_GE:     jump = ge;
                  COND_HI:     jump = fc && !fz;
                  COND_ALWAYS: jump = 1'b1;
                  default:     jump = 1'b1;
               endcase
               jump = jump ^ instruction[7];
               // Word offset: the immediate doubled, kept to a signed byte.
               off   = {imm[6:0], 1'b0};
               sum16 = base + {{8{off[7]}}, off};
               // A call saves the return address even when not taken.
               upd.ra_we = instruction[13];
               upd.ra    = pc_adv;
               upd.pc    = jump ? sum16 : pc_adv;
            end
            default: begin
               rsp.illegal = 1'b0;
            end
         endcase
         rsp.next_pc = upd.pc;
      end

      if (upd.x_we && (upd.x_idx == SR_INDEX)) begin
         sr_final = upd.x_data;
      end else if (upd.sr_we) begin
         sr_final = upd.sr;
      end else begin
         sr_final = sr_old;
      end
      rsp.flags = sr_final[3:0];
   end

endmodule

`default_nettype wire

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8-bit RISC step core.
// Instructions and load deliveries go in over the request stream. A
// scoreboard keeps its own copy of the register file, pc and pending load,
// predicts the response of every accepted transaction, and compares each
// response field by field. Both stream sides idle at random. The response
// side also holds off for long stretches so that the core backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import ebrc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1850;

   class risc_step_scoreboard;
      logic [7:0]   regs [NUM_REGS];
      logic [15:0]  pc;
      bit           load_waiting;
      logic [3:0]   load_reg;
      ebrc_rsp_type expected_q [$];
      int           errors;

      function new();
         foreach (regs[i]) regs[i] = 8'h00;
         pc = 16'h0000;
         load_waiting = 1'b0;
         load_reg = 4'd0;
         errors = 0;
      endfunction

      function logic [15:0] reg_pair(int lo);
         return {regs[(lo + 1) % NUM_REGS], regs[lo % NUM_REGS]};
      endfunction

      // Executes one transaction on the shadow state and returns its response.
      function ebrc_rsp_type execute(logic cmd, logic [15:0] ins, logic [7:0] ld);
         ebrc_rsp_type r;
         ebrc_fmt_type fmt;
         ebrc_op_type  op;
         logic [3:0]   x;
         logic [2:0]   mode;
         logic         sbit;
         logic [7:0]   imm, sr, op2, shl8;
         logic [15:0]  op1, res, shr16;
         bit           wr, setf, jump, sret, is_load, is_store;
         bit           c, v, n, z, ge, cin;
         int           acc;

         r = '0;
         if (cmd) begin
            if (load_waiting) begin
               regs[load_reg] = ld;
               load_waiting = 1'b0;
            end
            r.next_pc = pc;
            r.flags = regs[SR_INDEX][3:0];
            return r;
         end

         load_waiting = 1'b0;
         pc = pc + 16'd2;
         fmt = ebrc_fmt_type'(ins[15:14]);
         x = ins[7:4];
         mode = ins[12:10];
         sbit = ins[13];
         imm = {{2{ins[9]}}, ins[9:8], ins[3:0]};
         sr = regs[SR_INDEX];
         op = OP_ADD;
         op1 = 16'h0000;
         op2 = 8'h00;
         {wr, setf, jump, sret, is_load, is_store} = '0;

         case (fmt)
            FMT_RALU, FMT_IALU: begin
               op = ebrc_op_type'(ins[13:10]);
               if (op == OP_RSVD) begin
                  r.next_pc = pc;
                  r.illegal = 1'b1;
                  r.flags = sr[3:0];
                  return r;
               end
               wr = WRITE_SET[op];
               setf = FLAGS_SET[op];
               op1 = {8'h00, regs[x]};
               op2 = (fmt == FMT_RALU) ? regs[ins[3:0]] : imm;
            end
            FMT_MEM: begin
               case (ebrc_mem_mode_type'(mode))
                  MEM_SP:  op1 = STACK_BASE + {8'h00, regs[SP_INDEX]};
                  MEM_FP:  op1 = STACK_BASE + {8'h00, regs[FP_INDEX]};
                  MEM_RA:  op1 = reg_pair(0);
                  MEM_GB:  op1 = PAGE_BASE + {8'h00, regs[GB_INDEX]};
                  default: op1 = reg_pair(8 + 2 * (int'(mode) - 4));
               endcase
               op2 = imm;
               is_store = sbit;
               is_load = !sbit;
            end
            default: begin
               c = sr[FLAG_C_BIT];
               v = sr[FLAG_V_BIT];
               n = sr[FLAG_N_BIT];
               z = sr[FLAG_Z_BIT];
               ge = !v ? !n : c;
               case (ebrc_jmp_mode_type'(mode))
                  JMP_LOW:  op1 = LOW_BUILD;
                  JMP_HIGH: op1 = HIGH_BUILD;
                  JMP_REL:  op1 = pc;
                  JMP_RA:   op1 = reg_pair(0);
                  default:  op1 = reg_pair(8 + 2 * (int'(mode) - 4));
               endcase
               case (ebrc_cond_type'(ins[6:4]))
                  COND_C:  jump = c;
                  COND_V:  jump = v;
                  COND_N:  jump = n;
                  COND_Z:  jump = z;
                  COND_GT: jump = ge && !z;
                  COND_GE: jump = ge;
                  COND_HI: jump = c && !z;
                  default: jump = 1'b1;
               endcase
               if (ins[7]) jump = !jump;
               op2 = {imm[6:0], 1'b0};
               sret = sbit;
            end
         endcase

         // Address and target arithmetic go through the adder as a plain add.
         if (op inside {OP_SUB, OP_SBC, OP_CMP, OP_CMC}) op2 = ~op2;

         case (op)
            OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CMP, OP_CMC: begin
               if (op == OP_ADD) cin = 1'b0;
               else if (op == OP_SUB || op == OP_CMP) cin = 1'b1;
               else cin = sr[FLAG_C_BIT];
               acc = int'(op1[7:0]) + int'(op2) + int'(cin);
               sr[FLAG_C_BIT] = acc[8];
               sr[FLAG_V_BIT] = (op1[7] == op2[7]) && (op1[7] != acc[7]);
               acc = acc + int'(op1 & 16'hFF00) + (op2[7] ? 32'h0000FF00 : 32'h0);
               res = acc[15:0];
            end
            OP_AND: res = op1 & {8'h00, op2};
            OP_OR:  res = op1 | {8'h00, op2};
            OP_XOR: res = op1 ^ {8'h00, op2};
            OP_SHL: begin
               shl8 = op1[7:0] << op2[2:0];
               res = {op1[15:8], shl8};
            end
            OP_SHR: begin
               shr16 = op1 >> op2[2:0];
               res = {op1[15:8], shr16[7:0]};
            end
            OP_MOV: res = {8'h00, op2};
            OP_INS: res = {8'h00, op2[1:0], op1[5:0]};
            OP_BST: begin
               res = op1;
               res[op2[2:0]] = op2[3];
            end
            default: res = 16'h0000;
         endcase

         if (op == OP_TSB) sr[FLAG_Z_BIT] = op1[op2[2:0]];
         else if (op inside {OP_ADC, OP_SBC, OP_CMC}) begin
            if (res[7:0] != 8'h00) sr[FLAG_Z_BIT] = 1'b0;
         end else sr[FLAG_Z_BIT] = (res[7:0] == 8'h00);

         // The test-bit N flag follows the operand, not the result.
         if (op == OP_TSB) sr[FLAG_N_BIT] = (op2[5:3] == 3'b000) && op2[0];
         else sr[FLAG_N_BIT] = res[7];

         if (setf) regs[SR_INDEX] = sr;
         if (sret) {regs[1], regs[0]} = pc;
         if (jump) pc = res;

         r.next_pc = pc;
         if (is_load) begin
            load_waiting = 1'b1;
            load_reg = x;
            r.mem_load = 1'b1;
            r.mem_addr = res;
         end else if (is_store) begin
            r.mem_store = 1'b1;
            r.mem_addr = res;
            r.store_data = regs[x];
         end else if (wr) begin
            regs[x] = res[7:0];
         end
         r.flags = regs[SR_INDEX][3:0];
         return r;
      endfunction

      function void note_request(logic cmd, logic [15:0] ins, logic [7:0] ld);
         expected_q.push_back(execute(cmd, ins, ld));
      endfunction

      function void compare_field(string name, logic [15:0] exp_val,
                                  logic [15:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s: expected %h, actual %h", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(logic [47:0] d);
         ebrc_rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            $error("response transaction with no request outstanding: %h", d);
            errors++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         compare_field("next_pc", exp_rsp.next_pc, d[15:0]);
         compare_field("mem_load", exp_rsp.mem_load, d[16]);
         compare_field("mem_store", exp_rsp.mem_store, d[17]);
         compare_field("mem_addr", exp_rsp.mem_addr, d[33:18]);
         compare_field("store_data", exp_rsp.store_data, d[41:34]);
         compare_field("illegal", exp_rsp.illegal, d[42]);
         compare_field("flags", exp_rsp.flags, d[46:43]);
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // instruction[15:0], load_data[23:16]
   logic        req_tuser = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // next_pc[15:0], mem_load[16], mem_store[17], mem_addr[33:18],
   // store_data[41:34], illegal[42], flags[46:43], zero[47]
   logic [47:0] rsp_tdata;

   bit tx_steady = 1'b0;

   risc_step_scoreboard sb = new();

   eight_bit_risc_core_step i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [15:0] encode(ebrc_fmt_type f, logic [3:0] sel,
                                          logic [1:0] hi, logic [3:0] x,
                                          logic [3:0] lo);
      return {f, sel, hi, x, lo};
   endfunction

   task automatic send_item(input logic cmd, input logic [15:0] word,
                            input logic [7:0] data);
      int gap;
      gap = idle_length(tx_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {data, word};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, word, data);
   endtask

   task automatic send_word(input logic [15:0] word);
      send_item(1'b0, word, 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   initial begin : rsp_sink
      int cyc;
      int stall;
      cyc = 0;
      stall = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 900 == 400) begin
            // Long hold-off while requests keep coming, so the core backs up.
            rsp_tready <= 1'b0;
            repeat (150) @(negedge clock);
            cyc += 150;
         end else if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
            stall = idle_length(((cyc / 300) % 3) == 0);
         end
      end
   end

   initial begin : stimulus
      int sent;
      int next_drain;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(encode(FMT_IALU, OP_MOV, 2'b01, SP_INDEX, 4'hF));
      send_word(encode(FMT_IALU, OP_MOV, 2'b10, 4'd8, 4'h0));
      send_word(encode(FMT_IALU, OP_MOV, 2'b11, 4'd9, 4'hF));
      send_word(encode(FMT_RALU, OP_ADD, 2'b00, 4'd8, 4'd9));
      send_word(encode(FMT_RALU, OP_ADC, 2'b00, 4'd8, 4'd9));
      send_word(encode(FMT_RALU, OP_SUB, 2'b00, 4'd9, 4'd8));
      send_word(encode(FMT_IALU, OP_SBC, 2'b00, 4'd9, 4'h0));
      send_word(encode(FMT_RALU, OP_CMP, 2'b00, 4'd8, 4'd8));
      send_word(encode(FMT_IALU, OP_CMC, 2'b01, 4'd8, 4'hF));
      send_word(encode(FMT_RALU, OP_AND, 2'b00, 4'd15, 4'd9));
      send_word(encode(FMT_RALU, OP_OR, 2'b00, 4'd14, 4'd8));
      send_word(encode(FMT_RALU, OP_XOR, 2'b00, 4'd15, 4'd15));
      send_word(encode(FMT_IALU, OP_SHL, 2'b00, 4'd9, 4'h7));
      send_word(encode(FMT_IALU, OP_SHR, 2'b00, 4'd8, 4'h3));
      send_word(encode(FMT_RALU, OP_RSVD, 2'b11, 4'd9, 4'hF));
      send_word(encode(FMT_IALU, OP_INS, 2'b11, 4'd8, 4'hE));
      // Test bit with operand one, then with operand bits 5:3 nonzero.
      send_word(encode(FMT_IALU, OP_TSB, 2'b00, 4'd9, 4'h1));
      send_word(encode(FMT_IALU, OP_TSB, 2'b00, 4'd9, 4'h9));
      send_word(encode(FMT_IALU, OP_BST, 2'b00, 4'd14, 4'hF));
      send_word(encode(FMT_IALU, OP_BST, 2'b00, 4'd9, 4'h7));
      send_word(encode(FMT_MEM, {1'b0, MEM_SP}, 2'b10, FP_INDEX, 4'h0));
      send_item(1'b1, 16'hFFFF, 8'hA5);
      // A delivery with nothing pending must leave the state alone.
      send_item(1'b1, 16'h0000, 8'h5A);
      send_word(encode(FMT_MEM, {1'b0, MEM_GE}, 2'b01, 4'd6, 4'hF));
      // An instruction while a load is pending drops that load.
      send_word(encode(FMT_MEM, {1'b1, MEM_GH}, 2'b00, 4'd6, 4'h0));
      send_word(encode(FMT_JMP, {1'b1, JMP_REL}, 2'b11, {1'b0, COND_ALWAYS}, 4'hE));
      send_word(encode(FMT_JMP, {1'b1, JMP_RA}, 2'b00, {1'b1, COND_ALWAYS}, 4'h2));
      // A move writes the status register directly; MOV sets no flags of its own.
      send_word(encode(FMT_IALU, OP_MOV, 2'b00, SR_INDEX, 4'hF));
      wait_for_results();

      sent = 0;
      next_drain = 500;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 150 == 0) tx_steady = ($urandom_range(0, 3) == 0);
         if (sent >= next_drain) begin
            wait_for_results();
            next_drain += 500;
         end
         if (sb.load_waiting && $urandom_range(0, 3) != 0) begin
            send_item(1'b1, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            sent++;
         end else if (!sb.load_waiting && $urandom_range(0, 24) == 0) begin
            send_item(1'b1, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_word(16'($urandom_range(0, 65535)));
            sent++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("eight_bit_risc_core_step test passed");
      end else begin
         $display("eight_bit_risc_core_step test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("eight_bit_risc_core_step test failed");
      $finish;
   end

endmodule

`default_nettype wire
